[hw/rtl/pse_pkg.sv]
// Shared types, codes and defaults of the postfix stack evaluator.
`default_nettype none
package pse_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_W       = 7;
	localparam int STACK_DEPTH_D = 64;

	// Token function codes; anything above FN_DIV is an unknown operator
	localparam logic [2:0] FN_PUSH = 3'd0;
	localparam logic [2:0] FN_ADD  = 3'd1;
	localparam logic [2:0] FN_SUB  = 3'd2;
	localparam logic [2:0] FN_MUL  = 3'd3;
	localparam logic [2:0] FN_DIV  = 3'd4;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_DIVZERO   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic [30:0] token_value;
	} tok_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  top_value;
		logic        [DEPTH_W-1:0] depth;
		logic        [2:0]         status;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/pse_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/pse_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module pse_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pse_pkg::DATA_W-1:0] dividend,
	input  wire logic [pse_pkg::DATA_W-1:0] divisor,
	output logic                            done,
	output logic      [pse_pkg::DATA_W-1:0] quotient
);

	localparam int W   = pse_pkg::DATA_W;
	localparam int CW  = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  mb_q;
	logic          neg_q;
	logic [W:0]    trial;

	// Trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, mb_q};

	// Control: count iterations and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	// Datapath: load magnitudes, then shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (W'(0) - dividend) : dividend;
			mb_q  <= divisor[W-1] ? (W'(0) - divisor) : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

[hw/rtl/postfix_stack_evaluator.sv]
// Postfix stack evaluator: pushes numbers and applies add, subtract, multiply, divide.
// Usage:
//   Token channel (tok_valid / tok_stall / tok) carries one postfix token per request:
//   a push of a 31-bit value or an operator. Result channel (res_valid / res_stall / res)
//   returns exactly one result per token: new top of stack, depth and status.
// Sequencing:
//   A push or any token rejected with an error (overflow, underflow, unknown operator)
//   yields its result in the cycle after acceptance, and the next token may follow at once
//   if the result register is free. For the operators the operand below the top is
//   fetched from the stack RAM, the product is registered, and the quotient comes from a
//   bit-serial divider (32 iterations). One token is in work at a time; the top of stack
//   is held in a register beside the RAM.
// Reset:
//   arst_n clears the sequencer state, the stack pointer and the result valid flag; RAM
//   contents stay as they are and are never read before being written.
// Stall:
//   A result holds in its output register while res_stall is high; a new token is accepted
//   only when idle and when that register is free or being emptied in the same cycle.
`default_nettype none
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_D
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_valid,
	output logic               tok_stall,
	input  wire pse_pkg::tok_t tok,
	output logic               res_valid,
	input  wire logic          res_stall,
	output pse_pkg::res_t      res
);

	localparam int W   = pse_pkg::DATA_W;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);

	pse_pkg::state_t state_q, state_d;

	logic [SPW-1:0] sp_q, sp_d;
	logic [W-1:0]   top_q, top_d;
	logic [W-1:0]   a_q, b_q, r_q, r_d;
	logic [2:0]     func_q;
	logic [2:0]     status_q, status_d;
	logic           res_valid_q;
	pse_pkg::res_t  res_q, res_d;
	logic           load_res;
	logic           res_free;
	logic           accept;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [W-1:0]   mem_wdata;
	logic [AW-1:0]  mem_raddr;
	logic [W-1:0]   mem_rdata;

	logic           div_start;
	logic           div_done;
	logic [W-1:0]   div_quo;

	pse_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Operands are taken straight from the RAM and the top register at start
	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mem_rdata),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign res_free  = !res_valid_q || !res_stall;
	assign tok_stall = (state_q != pse_pkg::S_IDLE) || !res_free;
	assign accept    = tok_valid && !tok_stall;

	// Sequence one token: check, fetch, compute, write back
	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		top_d     = top_q;
		r_d       = r_q;
		status_d  = status_q;
		load_res  = 1'b0;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = sp_q[AW-1:0];
		mem_wdata = {1'b0, tok.token_value};
		mem_raddr = AW'(sp_q - SPW'(2));
		div_start = 1'b0;
		case (state_q)
			pse_pkg::S_IDLE: begin
				if (accept) begin
					res_d.top_value = (sp_q == '0) ? '0 : top_q;
					res_d.depth     = pse_pkg::DEPTH_W'(sp_q);
					res_d.status    = pse_pkg::ST_OK;
					if (tok.func == pse_pkg::FN_PUSH) begin
						load_res = 1'b1;
						if (sp_q >= SPW'(STACK_DEPTH)) begin
							res_d.status = pse_pkg::ST_OVERFLOW;
						end else begin
							mem_we          = 1'b1;
							sp_d            = sp_q + SPW'(1);
							top_d           = {1'b0, tok.token_value};
							res_d.top_value = {1'b0, tok.token_value};
							res_d.depth     = pse_pkg::DEPTH_W'(sp_q + SPW'(1));
						end
					end else if (!(tok.func inside {[pse_pkg::FN_PUSH:pse_pkg::FN_DIV]})) begin
						load_res     = 1'b1;
						res_d.status = pse_pkg::ST_UNKNOWN;
					end else if (sp_q < SPW'(2)) begin
						load_res     = 1'b1;
						res_d.status = pse_pkg::ST_UNDERFLOW;
					end else begin
						state_d = pse_pkg::S_READ;
					end
				end
			end
			pse_pkg::S_READ: begin
				status_d = pse_pkg::ST_OK;
				state_d  = pse_pkg::S_FIN;
				case (func_q)
					pse_pkg::FN_ADD: r_d = mem_rdata + top_q;
					pse_pkg::FN_SUB: r_d = mem_rdata - top_q;
					pse_pkg::FN_MUL: state_d = pse_pkg::S_MUL;
					default: begin
						if (top_q == '0) begin
							status_d = pse_pkg::ST_DIVZERO;
						end else begin
							state_d = pse_pkg::S_DIV;
						end
					end
				endcase
			end
			pse_pkg::S_MUL: begin
				r_d     = W'(a_q * b_q);
				state_d = pse_pkg::S_FIN;
			end
			pse_pkg::S_DIV: begin
				if (div_done) begin
					r_d     = div_quo;
					state_d = pse_pkg::S_FIN;
				end
			end
			pse_pkg::S_FIN: begin
				if (res_free) begin
					load_res     = 1'b1;
					res_d.status = status_q;
					if (status_q == pse_pkg::ST_OK) begin
						mem_we          = 1'b1;
						mem_waddr       = AW'(sp_q - SPW'(2));
						mem_wdata       = r_q;
						sp_d            = sp_q - SPW'(1);
						top_d           = r_q;
						res_d.top_value = r_q;
						res_d.depth     = pse_pkg::DEPTH_W'(sp_q - SPW'(1));
					end else begin
						res_d.top_value = top_q;
						res_d.depth     = pse_pkg::DEPTH_W'(sp_q);
					end
					state_d = pse_pkg::S_IDLE;
				end
			end
			default: state_d = pse_pkg::S_IDLE;
		endcase
		div_start = (state_q == pse_pkg::S_READ) && (state_d == pse_pkg::S_DIV);
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the stack pointer and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			sp_q <= sp_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Capture operands, intermediate result and the outgoing result
	always_ff @(posedge clk) begin
		top_q    <= top_d;
		r_q      <= r_d;
		status_q <= status_d;
		if (accept) begin
			func_q <= tok.func;
		end
		if (state_q == pse_pkg::S_READ) begin
			a_q <= mem_rdata;
			b_q <= top_q;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire
